[sv/assert_macros.svh]
// Assertion helper macros for the RTL in this folder.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication check failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication check failed");

`endif

[sv/qvr_pkg.sv]
// Types, widths and helper functions for the quaternion vector rotator.
// No dependencies; imported by quaternion_vector_rotate.
package qvr_pkg;

   localparam int DATA_W   = 32;          // every payload field
   localparam int UV_W     = 64;          // exact q cross v
   localparam int PP_LO_W  = DATA_W + 33; // q * unsigned low half of u
   localparam int PP_HI_W  = 2 * DATA_W;  // q * signed high half of u
   localparam int PROD_W   = 96;          // exact q * u
   localparam int SUM_W    = PROD_W + 1;  // sum of three products
   localparam int LANES    = 3;

   localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

   // 32 x 64 product held as a 32 x 33 and a 32 x 32 partial product
   typedef struct packed {
      logic [PP_LO_W-1:0] lo;
      logic [PP_HI_W-1:0] hi;
   } part_type;

   function automatic part_type part_mul(input logic signed [DATA_W-1:0] a,
                                         input logic signed [UV_W-1:0] b);
      part_type r;
      logic signed [PP_LO_W-1:0] lo;
      logic signed [PP_HI_W-1:0] hi;
      lo = a * $signed({1'b0, b[DATA_W-1:0]});
      hi = a * $signed(b[UV_W-1:DATA_W]);
      r.lo = lo;
      r.hi = hi;
      return r;
   endfunction

   function automatic logic signed [PROD_W-1:0] part_join(input part_type p);
      logic signed [PROD_W-1:0] r;
      r = $signed({p.hi, {DATA_W{1'b0}}}) +
          $signed({{(PROD_W-PP_LO_W){p.lo[PP_LO_W-1]}}, p.lo});
      return r;
   endfunction

endpackage

[sv/quaternion_vector_rotate.sv]
// Quaternion vector rotator: out = v + 2*(w*u + qv x u), u = qv x v.
//
// Input transaction (req_*): quaternion x, y, z, w (signed fixed point with
// QUAT_FRAC_BITS fraction bits) and a signed 3-vector. Result transaction
// (rsp_*): rotated vector in the input vector's format, rounded toward minus
// infinity and clipped to 32 bits; rsp_saturated flags any clipped component.
// Both channels are valid/ready.
//
// Six register stages: vector products, u, partial products of q*u,
// product merge, three-way sum, shift/add/saturate into the output register.
// Throughput is one transaction per clock while rsp_ready stays high; each
// stage holds at most a 32x33 multiply or one three-operand add.
//
// Reset clears all stage valid bits; req_ready is low while reset is high.
// When the receiver stalls, full stages hold their data and empty stages
// keep filling, so req_ready drops only once every stage is occupied.
`include "assert_macros.svh"

module quaternion_vector_rotate
   import qvr_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [DATA_W-1:0] req_quat_x,
   input  logic [DATA_W-1:0] req_quat_y,
   input  logic [DATA_W-1:0] req_quat_z,
   input  logic [DATA_W-1:0] req_quat_w,
   input  logic [DATA_W-1:0] req_vec_x,
   input  logic [DATA_W-1:0] req_vec_y,
   input  logic [DATA_W-1:0] req_vec_z,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_rot_x,
   output logic [DATA_W-1:0] rsp_rot_y,
   output logic [DATA_W-1:0] rsp_rot_z,
   output logic              rsp_saturated
);

   localparam int NS    = 6;
   localparam int S_SUM = 4;
   localparam int S_OUT = 5;
   // floor(2*s / 2^(2F)) == floor(s / 2^(2F-1))
   localparam int SH    = 2 * QUAT_FRAC_BITS - 1;
   localparam int SHR_W = SUM_W - SH;
   localparam int FIN_W = SHR_W + 1;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   stage_en;

   logic signed [DATA_W-1:0] q_req [4];
   logic signed [DATA_W-1:0] v_req [LANES];

   // stage 0: q_j*v_k and q_k*v_j
   logic signed [UV_W-1:0]   pb0_in [LANES];
   logic signed [UV_W-1:0]   pc0_in [LANES];
   logic signed [UV_W-1:0]   pb0_ff [LANES];
   logic signed [UV_W-1:0]   pc0_ff [LANES];
   logic signed [DATA_W-1:0] q0_ff  [4];
   logic signed [DATA_W-1:0] v0_ff  [LANES];
   // stage 1: u
   logic signed [UV_W-1:0]   u1_in  [LANES];
   logic signed [UV_W-1:0]   u1_ff  [LANES];
   logic signed [DATA_W-1:0] q1_ff  [4];
   logic signed [DATA_W-1:0] v1_ff  [LANES];
   // stage 2: partial products of w*u_i, q_j*u_k, q_k*u_j
   part_type                 pa2_in [LANES];
   part_type                 pb2_in [LANES];
   part_type                 pc2_in [LANES];
   part_type                 pa2_ff [LANES];
   part_type                 pb2_ff [LANES];
   part_type                 pc2_ff [LANES];
   logic signed [DATA_W-1:0] v2_ff  [LANES];
   // stage 3: full products
   logic signed [PROD_W-1:0] a3_in  [LANES];
   logic signed [PROD_W-1:0] b3_in  [LANES];
   logic signed [PROD_W-1:0] c3_in  [LANES];
   logic signed [PROD_W-1:0] a3_ff  [LANES];
   logic signed [PROD_W-1:0] b3_ff  [LANES];
   logic signed [PROD_W-1:0] c3_ff  [LANES];
   logic signed [DATA_W-1:0] v3_ff  [LANES];
   // stage 4: w*u + qv x u
   logic signed [SUM_W-1:0]  sum4_in [LANES];
   logic signed [SUM_W-1:0]  sum4_ff [LANES];
   logic signed [DATA_W-1:0] v4_ff   [LANES];
   // stage 5: output register
   logic signed [FIN_W-1:0]  fin_in  [LANES];
   logic [DATA_W-1:0]        rot_in  [LANES];
   logic [LANES-1:0]         clip_in;
   logic [DATA_W-1:0]        rot_ff  [LANES];
   logic                     sat_ff;

   assign q_req[0] = req_quat_x;
   assign q_req[1] = req_quat_y;
   assign q_req[2] = req_quat_z;
   assign q_req[3] = req_quat_w;
   assign v_req[0] = req_vec_x;
   assign v_req[1] = req_vec_y;
   assign v_req[2] = req_vec_z;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      stage_en[NS] = rsp_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   end

   assign req_ready = stage_en[0] && !reset;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      localparam int J = (i + 1) % LANES;
      localparam int K = (i + 2) % LANES;
      logic [FIN_W-DATA_W:0] top_bits;

      assign pb0_in[i] = q_req[J] * v_req[K];
      assign pc0_in[i] = q_req[K] * v_req[J];

      assign u1_in[i] = pb0_ff[i] - pc0_ff[i];

      assign pa2_in[i] = part_mul(q1_ff[3], u1_ff[i]);
      assign pb2_in[i] = part_mul(q1_ff[J], u1_ff[K]);
      assign pc2_in[i] = part_mul(q1_ff[K], u1_ff[J]);

      assign a3_in[i] = part_join(pa2_ff[i]);
      assign b3_in[i] = part_join(pb2_ff[i]);
      assign c3_in[i] = part_join(pc2_ff[i]);

      assign sum4_in[i] = $signed({a3_ff[i][PROD_W-1], a3_ff[i]}) +
                          $signed({b3_ff[i][PROD_W-1], b3_ff[i]}) -
                          $signed({c3_ff[i][PROD_W-1], c3_ff[i]});

      // arithmetic shift is a floor; then add v back
      assign fin_in[i] = $signed({sum4_ff[i][SUM_W-1], sum4_ff[i][SUM_W-1:SH]}) +
                         $signed({{(FIN_W-DATA_W){v4_ff[i][DATA_W-1]}}, v4_ff[i]});

      assign top_bits   = fin_in[i][FIN_W-1:DATA_W-1];
      assign clip_in[i] = !((&top_bits) || !(|top_bits));
      assign rot_in[i]  = !clip_in[i]          ? fin_in[i][DATA_W-1:0] :
                          fin_in[i][FIN_W-1]   ? SAT_MIN : SAT_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         q0_ff <= q_req;
         v0_ff <= v_req;
         pb0_ff <= pb0_in;
         pc0_ff <= pc0_in;
      end
      if (stage_en[1]) begin
         u1_ff <= u1_in;
         q1_ff <= q0_ff;
         v1_ff <= v0_ff;
      end
      if (stage_en[2]) begin
         pa2_ff <= pa2_in;
         pb2_ff <= pb2_in;
         pc2_ff <= pc2_in;
         v2_ff  <= v1_ff;
      end
      if (stage_en[3]) begin
         a3_ff <= a3_in;
         b3_ff <= b3_in;
         c3_ff <= c3_in;
         v3_ff <= v2_ff;
      end
      if (stage_en[S_SUM]) begin
         sum4_ff <= sum4_in;
         v4_ff   <= v3_ff;
      end
      if (stage_en[S_OUT]) begin
         rot_ff <= rot_in;
         sat_ff <= |clip_in;
      end
   end

   assign rsp_valid     = vld_ff[S_OUT];
   assign rsp_rot_x     = rot_ff[0];
   assign rsp_rot_y     = rot_ff[1];
   assign rsp_rot_z     = rot_ff[2];
   assign rsp_saturated = sat_ff;

   // terms for the checks below
   logic v4_zero;
   logic sum4_zero;
   logic rot_on_rail;

   assign v4_zero     = (v4_ff[0] == '0) && (v4_ff[1] == '0) && (v4_ff[2] == '0);
   assign sum4_zero   = (sum4_ff[0] == '0) && (sum4_ff[1] == '0) && (sum4_ff[2] == '0);
   assign rot_on_rail = (rsp_rot_x == SAT_MAX) || (rsp_rot_x == SAT_MIN) ||
                        (rsp_rot_y == SAT_MAX) || (rsp_rot_y == SAT_MIN) ||
                        (rsp_rot_z == SAT_MAX) || (rsp_rot_z == SAT_MIN);

   // input backs up only when every stage holds a transaction
   `ASSERT_IMPLIES(a_full_before_stall, clock, reset, !req_ready, &vld_ff)

   `ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && req_ready, vld_ff[0])

   // a zero vector yields a zero sum regardless of the quaternion
   `ASSERT_IMPLIES(a_zero_vector, clock, reset, vld_ff[S_SUM] && v4_zero, sum4_zero)

   // a clipped result carries at least one rail value
   `ASSERT_IMPLIES(a_sat_rail, clock, reset, rsp_valid && rsp_saturated, rot_on_rail)

endmodule

[test/tb_quaternion_vector_rotate.sv]
// Testbench for quaternion_vector_rotate: directed and random rotations with
// random stalls on both channels, checked against an exact wide-integer predictor.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
`timescale 1ns / 100ps

module tb_quaternion_vector_rotate
   import qvr_pkg::*;
();

   localparam int QFRAC       = 30;
   localparam int WIDE        = 160;   // holds every exact intermediate with margin
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 12;
   localparam int RANDOM_ITEMS = 1600;

   localparam logic [DATA_W-1:0] ONE_Q   = 32'h4000_0000;  // 1.0 in Q2.30
   localparam logic [DATA_W-1:0] HALF_Q  = 32'h2000_0000;
   localparam logic [DATA_W-1:0] COS45_Q = 32'h2D41_3CCD;  // sqrt(0.5)
   localparam logic [DATA_W-1:0] ONE_V   = 32'h0001_0000;  // 1.0 in Q16.16

   typedef struct packed {
      logic [DATA_W-1:0] quat_x;
      logic [DATA_W-1:0] quat_y;
      logic [DATA_W-1:0] quat_z;
      logic [DATA_W-1:0] quat_w;
      logic [DATA_W-1:0] vec_x;
      logic [DATA_W-1:0] vec_y;
      logic [DATA_W-1:0] vec_z;
   } rot_request_type;

   typedef struct packed {
      logic [DATA_W-1:0] rot_x;
      logic [DATA_W-1:0] rot_y;
      logic [DATA_W-1:0] rot_z;
      logic              saturated;
   } rot_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [DATA_W-1:0] req_quat_x;
   logic [DATA_W-1:0] req_quat_y;
   logic [DATA_W-1:0] req_quat_z;
   logic [DATA_W-1:0] req_quat_w;
   logic [DATA_W-1:0] req_vec_x;
   logic [DATA_W-1:0] req_vec_y;
   logic [DATA_W-1:0] req_vec_z;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [DATA_W-1:0] rsp_rot_x;
   logic [DATA_W-1:0] rsp_rot_y;
   logic [DATA_W-1:0] rsp_rot_z;
   logic              rsp_saturated;

   rot_result_type rot_expected[$];
   int             errors;
   int             stall_cycles;
   bit             burst_mode;      // no idling on either side while set

   quaternion_vector_rotate #(
      .QUAT_FRAC_BITS(QFRAC)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_quat_x    (req_quat_x),
      .req_quat_y    (req_quat_y),
      .req_quat_z    (req_quat_z),
      .req_quat_w    (req_quat_w),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rot_x     (rsp_rot_x),
      .rsp_rot_y     (rsp_rot_y),
      .rsp_rot_z     (rsp_rot_z),
      .rsp_saturated (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // v + 2*(w*u + qv x u) with u = qv x v, floored and clipped to 32 bits
   function automatic rot_result_type rotate_vector(input rot_request_type r);
      logic signed [WIDE-1:0] q[3];
      logic signed [WIDE-1:0] v[3];
      logic signed [WIDE-1:0] u[3];
      logic signed [WIDE-1:0] w;
      logic signed [WIDE-1:0] s;
      logic [DATA_W-1:0]      lane[3];
      rot_result_type         res;
      res = '0;
      q[0] = $signed(r.quat_x);
      q[1] = $signed(r.quat_y);
      q[2] = $signed(r.quat_z);
      w    = $signed(r.quat_w);
      v[0] = $signed(r.vec_x);
      v[1] = $signed(r.vec_y);
      v[2] = $signed(r.vec_z);
      if (r.vec_x == '0 && r.vec_y == '0 && r.vec_z == '0)
         return res;
      for (int i = 0; i < 3; i++)
         u[i] = q[(i+1)%3] * v[(i+2)%3] - q[(i+2)%3] * v[(i+1)%3];
      for (int i = 0; i < 3; i++) begin
         s = q[(i+1)%3] * u[(i+2)%3] - q[(i+2)%3] * u[(i+1)%3] + w * u[i];
         s = ((s + s) >>> (2 * QFRAC)) + v[i];
         if (&s[WIDE-1:DATA_W-1] || ~|s[WIDE-1:DATA_W-1]) begin
            lane[i] = s[DATA_W-1:0];
         end else begin
            lane[i] = s[WIDE-1] ? SAT_MIN : SAT_MAX;
            res.saturated = 1'b1;
         end
      end
      res.rot_x = lane[0];
      res.rot_y = lane[1];
      res.rot_z = lane[2];
      return res;
   endfunction

   // magnitudes spread over all scales, with the edge patterns mixed in
   function automatic logic [DATA_W-1:0] pick_word();
      logic [DATA_W-1:0] word;
      case ($urandom_range(0, 15))
         0: word = 32'h0000_0000;
         1: word = 32'h7FFF_FFFF;
         2: word = 32'h8000_0000;
         3: word = 32'hFFFF_FFFF;
         4: word = ONE_Q;
         5: word = -ONE_Q;
         default: word = $signed($urandom) >>> $urandom_range(0, 31);
      endcase
      return word;
   endfunction

   function automatic rot_request_type make_rotation(
      input logic [DATA_W-1:0] qx, input logic [DATA_W-1:0] qy,
      input logic [DATA_W-1:0] qz, input logic [DATA_W-1:0] qw,
      input logic [DATA_W-1:0] vx, input logic [DATA_W-1:0] vy,
      input logic [DATA_W-1:0] vz);
      rot_request_type r;
      r.quat_x = qx;
      r.quat_y = qy;
      r.quat_z = qz;
      r.quat_w = qw;
      r.vec_x  = vx;
      r.vec_y  = vy;
      r.vec_z  = vz;
      return r;
   endfunction

   // returns in the time step of the accepting edge with req_valid still high
   task automatic send_rotation(input rot_request_type r);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_quat_x <= r.quat_x;
      req_quat_y <= r.quat_y;
      req_quat_z <= r.quat_z;
      req_quat_w <= r.quat_w;
      req_vec_x  <= r.vec_x;
      req_vec_y  <= r.vec_y;
      req_vec_z  <= r.vec_z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rot_expected.push_back(rotate_vector(r));
   endtask

   // sender holds off until the pipeline has fully drained
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (rot_expected.size() != 0) @(posedge clock);
   endtask

   task automatic test_known_rotations();
      // identity, half turn about z, quarter turn about x, negated identity, third turn about the diagonal
      send_rotation(make_rotation('0, '0, '0, ONE_Q, ONE_V, 2 * ONE_V, -3 * ONE_V));
      send_rotation(make_rotation('0, '0, ONE_Q, '0, ONE_V, 2 * ONE_V, 3 * ONE_V));
      send_rotation(make_rotation(COS45_Q, '0, '0, COS45_Q, '0, ONE_V, '0));
      send_rotation(make_rotation('0, '0, '0, -ONE_Q, 32'h1234_5678, 32'h8765_4321, 32'h1));
      send_rotation(make_rotation(HALF_Q, HALF_Q, HALF_Q, HALF_Q,
                                  5 * ONE_V, -7 * ONE_V, ONE_V));
   endtask

   task automatic test_zero_vector();
      send_rotation(make_rotation(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, '0, '0, '0));
      send_rotation(make_rotation(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, '0, '0, '0));
   endtask

   task automatic test_field_extremes();
      send_rotation(make_rotation(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF));
      send_rotation(make_rotation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000));
      send_rotation(make_rotation(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1));
      send_rotation(make_rotation(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF));
      send_rotation(make_rotation(32'h1, '0, '0, '0, 32'h7FFF_FFFF, '0, 32'h8000_0000));
   endtask

   task automatic test_saturation();
      // only the y lane overflows, then only the y lane underflows, then y underflows while z overflows
      send_rotation(make_rotation(ONE_Q, '0, '0, '0, 32'h10, 32'h8000_0000, 32'h20));
      send_rotation(make_rotation(32'h7FFF_FFFF, '0, '0, '0, '0, 32'h2000_0000, '0));
      send_rotation(make_rotation(32'h7FFF_FFFF, '0, '0, 32'h7FFF_FFFF,
                                  '0, 32'h4000_0000, '0));
   endtask

   task automatic test_floor_rounding();
      // fractional negative terms must round down, not toward zero
      send_rotation(make_rotation('0, '0, HALF_Q, '0, 32'h1, '0, '0));
      send_rotation(make_rotation('0, '0, 32'h1, '0, 32'h1, '0, '0));
      send_rotation(make_rotation(32'h1, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h1));
   endtask

   task automatic test_drain_pause();
      rot_request_type r;
      for (int i = 0; i < 8; i++) begin
         r = make_rotation(pick_word(), pick_word(), pick_word(), pick_word(),
                           pick_word(), pick_word(), pick_word());
         send_rotation(r);
      end
      hold_until_drained();
   endtask

   task automatic test_random_rotations();
      rot_request_type r;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0)
            burst_mode = ($urandom_range(0, 3) == 0);
         r = make_rotation(pick_word(), pick_word(), pick_word(), pick_word(),
                           pick_word(), pick_word(), pick_word());
         if ($urandom_range(0, 15) == 0) begin
            r.vec_x = '0;
            r.vec_y = '0;
            r.vec_z = '0;
         end
         send_rotation(r);
      end
      burst_mode = 1'b0;
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                              input logic [DATA_W-1:0] act_val);
      if (exp_val !== act_val) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val,
                  act_val);
      end
   endtask

   // result side: random backpressure, one draw per transaction
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // checker and watchdog
   always @(posedge clock) begin
      rot_result_type exp_res;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (rot_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none actual %h %h %h %b",
                        $time, rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_saturated);
            end else begin
               exp_res = rot_expected.pop_front();
               check_field("rot_x", exp_res.rot_x, rsp_rot_x);
               check_field("rot_y", exp_res.rot_y, rsp_rot_y);
               check_field("rot_z", exp_res.rot_z, rsp_rot_z);
               check_field("saturated", {31'b0, exp_res.saturated}, {31'b0, rsp_saturated});
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      errors       = 0;
      stall_cycles = 0;
      burst_mode   = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_quat_x   = '0;
      req_quat_y   = '0;
      req_quat_z   = '0;
      req_quat_w   = '0;
      req_vec_x    = '0;
      req_vec_y    = '0;
      req_vec_z    = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_known_rotations();
      test_zero_vector();
      test_field_extremes();
      test_saturation();
      test_floor_rounding();
      test_drain_pause();
      test_random_rotations();

      hold_until_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
